// ===== src/dcb_pkg.sv =====
`timescale 1ns / 1ps
package dcb_pkg;

  localparam int MASS_W        = 20;
  localparam int AMP_W         = 40;
  localparam int PAR_W         = 20;
  localparam int POW_W         = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;

  localparam int LOG_FRAC = 30;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam int Q_SHIFT  = 24;
  localparam int QNW      = POW_W + Q_SHIFT;
  localparam int LW       = QNW + 1;
  localparam int KW       = $clog2(LW);
  localparam int LG_W     = KW + LOG_FRAC;
  localparam int LH       = LG_W / 2;
  localparam int YW       = 32;
  localparam int SQ_W     = 64;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int HW       = LOG_FRAC + 7;
  localparam int EW       = POW_W + LG_W;
  localparam int RND_SH   = 23;
  localparam int PROD_SPLIT = AMP_W / 2;

  localparam logic [AMP_W-1:0] OUT_MAX = {AMP_W{1'b1}};

  localparam logic [AMP_W-1:0] RST_AMPLITUDE   = 40'd0;
  localparam logic [PAR_W-1:0] RST_PEAK_MEAN   = 20'd202899;
  localparam logic [PAR_W-1:0] RST_PEAK_WIDTH  = 20'd4588;
  localparam logic [PAR_W-1:0] RST_LEFT_CUT    = 20'd65536;
  localparam logic [POW_W-1:0] RST_LEFT_POWER  = 24'd655360;
  localparam logic [PAR_W-1:0] RST_RIGHT_CUT   = 20'd131072;
  localparam logic [POW_W-1:0] RST_RIGHT_POWER = 24'd655360;

  typedef enum logic [1:0] {
    REG_CORE  = 2'd0,
    REG_LEFT  = 2'd1,
    REG_RIGHT = 2'd2
  } region_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE   = 3'd0,
    CFG_PEAK_MEAN   = 3'd1,
    CFG_PEAK_WIDTH  = 3'd2,
    CFG_LEFT_CUT    = 3'd3,
    CFG_LEFT_POWER  = 3'd4,
    CFG_RIGHT_CUT   = 3'd5,
    CFG_RIGHT_POWER = 3'd6
  } cfg_idx_t;

endpackage

// ===== src/dcb_in_if.sv =====
`timescale 1ns / 1ps
interface dcb_in_if
  import dcb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MASS_W-1:0] mass_in;

  modport source(output valid, output mass_in, input ready);
  modport sink(input valid, input mass_in, output ready);
endinterface

// ===== src/dcb_out_if.sv =====
`timescale 1ns / 1ps
interface dcb_out_if
  import dcb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [AMP_W-1:0] shape_value;
  logic [1:0]       region;

  modport source(output valid, output shape_value, output region, input ready);
  modport sink(input valid, input shape_value, input region, output ready);
endinterface

// ===== src/dcb_cfg_if.sv =====
`timescale 1ns / 1ps
interface dcb_cfg_if
  import dcb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [AMP_W-1:0]     data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/dcb_div_cell.sv =====
`timescale 1ns / 1ps
module dcb_div_cell
  import dcb_pkg::*;
#(
  parameter int NW = QNW,
  parameter int DW = PAR_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [DW-1:0] div_i,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] nq_o,
  output logic [DW-1:0] div_o
);

  logic [DW:0] trial;
  logic        ge;

  assign trial = {rem_i, nq_i[NW-1]};
  assign ge    = trial >= {1'b0, div_i};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? DW'(trial - {1'b0, div_i}) : trial[DW-1:0];
      nq_o  <= {nq_i[NW-2:0], ge};
      div_o <= div_i;
    end
  end

endmodule

// ===== src/dcb_lg_cell.sv =====
`timescale 1ns / 1ps
module dcb_lg_cell
  import dcb_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [YW-1:0]       y_i,
  input  logic [LOG_FRAC-1:0] frac_i,
  output logic [YW-1:0]       y_o,
  output logic [LOG_FRAC-1:0] frac_o
);

  logic [2*YW-1:0] p;

  assign p = (2*YW)'(y_i) * (2*YW)'(y_i);

  always_ff @(posedge clk) begin
    if (en) begin
      y_o    <= p[2*YW-1] ? p[2*YW-1:YW] : p[2*YW-2:YW-1];
      frac_o <= {frac_i[LOG_FRAC-2:0], p[2*YW-1]};
    end
  end

endmodule

// ===== src/dcb_sqrt_cell.sv =====
`timescale 1ns / 1ps
module dcb_sqrt_cell
  import dcb_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] v_i,
  input  logic [SQ_W-1:0] r_i,
  output logic [SQ_W-1:0] v_o,
  output logic [SQ_W-1:0] r_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

  logic [SQ_W:0] t;
  logic          ge;

  assign t  = {1'b0, r_i} + {1'b0, BIT};
  assign ge = {1'b0, v_i} >= t;

  always_ff @(posedge clk) begin
    if (en) begin
      v_o <= ge ? (v_i - t[SQ_W-1:0]) : v_i;
      r_o <= ge ? ((r_i >> 1) + BIT) : (r_i >> 1);
    end
  end

endmodule

// ===== src/double_sided_crystal_ball_eval_top.sv =====
`timescale 1ns / 1ps
// channel  dir  payload                   handshake
// sample   in   mass_in                   valid/ready
// result   out  shape_value, region       valid/ready
// cfg      in   index, data               valid/ready (ready always high)
//
// One word per cycle while the skid register is empty; the latency is set
// by the bit-serial divider cells, the 30 squaring cells of the log and
// the 30 x 32 square-root cells of the exponential.
// rst is synchronous; it clears the valid line and skid flag, resets the config.
// A stalled result parks in a skid register; the pipe freezes only when it is full.
module double_sided_crystal_ball_eval_top
  import dcb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  dcb_cfg_if.sink   cfg,
  dcb_in_if.sink    sample,
  dcb_out_if.source result
);

  localparam int NW1    = MASS_W + FRAC_BITS;
  localparam int SQ_IN  = FRAC_BITS + 3;
  localparam int HS_SH  = 2 * FRAC_BITS + 1 - LOG_FRAC;
  localparam int D_SH   = Q_SHIFT - FRAC_BITS;
  localparam int NSQ    = LOG_FRAC * SQ_STEPS;
  localparam int LAT    = NW1 + 4 + QNW + 1 + KW + LOG_FRAC + 4 + NSQ + 3;

  // config
  logic [AMP_W-1:0] amplitude;
  logic [PAR_W-1:0] peak_mean, peak_width, left_cut, right_cut;
  logic [POW_W-1:0] left_power, right_power;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude   <= RST_AMPLITUDE;
      peak_mean   <= RST_PEAK_MEAN;
      peak_width  <= RST_PEAK_WIDTH;
      left_cut    <= RST_LEFT_CUT;
      left_power  <= RST_LEFT_POWER;
      right_cut   <= RST_RIGHT_CUT;
      right_power <= RST_RIGHT_POWER;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_AMPLITUDE:   amplitude   <= cfg.data;
        CFG_PEAK_MEAN:   peak_mean   <= cfg.data[PAR_W-1:0];
        CFG_PEAK_WIDTH:  peak_width  <= cfg.data[PAR_W-1:0];
        CFG_LEFT_CUT:    left_cut    <= cfg.data[PAR_W-1:0];
        CFG_LEFT_POWER:  left_power  <= cfg.data[POW_W-1:0];
        CFG_RIGHT_CUT:   right_cut   <= cfg.data[PAR_W-1:0];
        CFG_RIGHT_POWER: right_power <= cfg.data[POW_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PAR_W-1:0] sig_e, a1_e, a2_e;
  assign sig_e = (peak_width == '0) ? PAR_W'(1) : peak_width;
  assign a1_e  = (left_cut == '0) ? PAR_W'(1) : left_cut;
  assign a2_e  = (right_cut == '0) ? PAR_W'(1) : right_cut;

  // flow control
  logic             en;
  logic [LAT-1:0]   vld;
  logic             skid_full;
  logic [AMP_W-1:0] skid_value;
  region_t          skid_region;
  logic [AMP_W-1:0] o_value;
  region_t          o_region;

  assign en           = !skid_full;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], sample.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (result.ready) begin
        skid_full <= 1'b0;
      end
    end else if (vld[LAT-1] && !result.ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_value  <= o_value;
      skid_region <= o_region;
    end
  end

  assign result.valid       = skid_full || vld[LAT-1];
  assign result.shape_value = skid_full ? skid_value : o_value;
  assign result.region      = skid_full ? skid_region : o_region;

  // t = |m - m0| / sigma
  logic              neg_in;
  logic [MASS_W-1:0] dm_in;
  assign neg_in = sample.mass_in < peak_mean;
  assign dm_in  = neg_in ? (peak_mean - sample.mass_in) : (sample.mass_in - peak_mean);

  logic [PAR_W-1:0] tm_rem [NW1];
  logic [NW1-1:0]   tm_nq  [NW1];
  logic [PAR_W-1:0] tm_div [NW1];
  logic             tm_neg [NW1];

  for (genvar i = 0; i < NW1; i++) begin : g_tm
    if (i == 0) begin : g_first
      dcb_div_cell #(.NW(NW1), .DW(PAR_W)) u_cell (
        .clk(clk), .en(en),
        .rem_i('0), .nq_i({dm_in, FRAC_BITS'(0)}), .div_i(sig_e),
        .rem_o(tm_rem[i]), .nq_o(tm_nq[i]), .div_o(tm_div[i])
      );
      always_ff @(posedge clk) begin
        if (en) tm_neg[i] <= neg_in;
      end
    end else begin : g_next
      dcb_div_cell #(.NW(NW1), .DW(PAR_W)) u_cell (
        .clk(clk), .en(en),
        .rem_i(tm_rem[i-1]), .nq_i(tm_nq[i-1]), .div_i(tm_div[i-1]),
        .rem_o(tm_rem[i]), .nq_o(tm_nq[i]), .div_o(tm_div[i])
      );
      always_ff @(posedge clk) begin
        if (en) tm_neg[i] <= tm_neg[i-1];
      end
    end
  end

  // region decision
  logic [NW1-1:0] tm;
  logic           is_left, is_right;
  logic [NW1-1:0] a_sel;
  region_t        dec_region;
  logic [NW1-1:0] dec_d, dec_hx;

  assign tm       = tm_nq[NW1-1];
  assign is_left  = tm_neg[NW1-1] && (tm > NW1'(a1_e));
  assign is_right = !tm_neg[NW1-1] && (tm > NW1'(a2_e));
  assign a_sel    = is_left ? NW1'(a1_e) : NW1'(a2_e);

  always_ff @(posedge clk) begin
    if (en) begin
      dec_region <= is_left ? REG_LEFT : (is_right ? REG_RIGHT : REG_CORE);
      dec_d      <= tm - a_sel;
      dec_hx     <= (is_left || is_right) ? a_sel : tm;
    end
  end

  // h(x) = x^2/2 * log2(e)
  region_t          h1_region, h2_region, h3_region;
  logic [NW1-1:0]   h1_d, h2_d, h3_d;
  logic             h1_cap, h2_cap;
  logic [2*SQ_IN-1:0] h1_sq;
  logic [SQ_IN-1:0] hxs;
  logic [63:0]      hs;
  logic [33:0]      h2_ph;
  logic [62:0]      h2_pl;
  logic [HW-1:0]    h3_h;

  assign hxs = dec_hx[SQ_IN-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      h1_region <= dec_region;
      h1_d      <= dec_d;
      h1_cap    <= dec_hx >= (NW1'(8) << FRAC_BITS);
      h1_sq     <= (2*SQ_IN)'(hxs) * (2*SQ_IN)'(hxs);
    end
  end

  if (HS_SH >= 0) begin : g_hs_r
    assign hs = 64'(h1_sq) >> HS_SH;
  end else begin : g_hs_l
    assign hs = 64'(h1_sq) << (-HS_SH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h2_region <= h1_region;
      h2_d      <= h1_d;
      h2_cap    <= h1_cap;
      h2_ph     <= 34'(hs[34:32]) * 34'(LOG2E_Q30);
      h2_pl     <= 63'(hs[31:0]) * 63'(LOG2E_Q30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h3_region <= h2_region;
      h3_d      <= h2_d;
      h3_h      <= h2_cap ? (HW'(64) << LOG_FRAC)
                          : (HW'({h2_ph, 2'b00}) + HW'(h2_pl >> LOG_FRAC));
    end
  end

  // q = (n << 24) / a
  logic [PAR_W-1:0] q_a_in;
  logic [POW_W-1:0] q_n_in;
  assign q_a_in = (h3_region == REG_LEFT) ? a1_e : a2_e;
  assign q_n_in = (h3_region == REG_LEFT) ? left_power : right_power;

  logic [PAR_W-1:0] q_rem    [QNW];
  logic [QNW-1:0]   q_nq     [QNW];
  logic [PAR_W-1:0] q_div    [QNW];
  region_t          q_region [QNW];
  logic [NW1-1:0]   q_d      [QNW];
  logic [HW-1:0]    q_h      [QNW];

  for (genvar i = 0; i < QNW; i++) begin : g_q
    if (i == 0) begin : g_first
      dcb_div_cell #(.NW(QNW), .DW(PAR_W)) u_cell (
        .clk(clk), .en(en),
        .rem_i('0), .nq_i({q_n_in, Q_SHIFT'(0)}), .div_i(q_a_in),
        .rem_o(q_rem[i]), .nq_o(q_nq[i]), .div_o(q_div[i])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          q_region[i] <= h3_region;
          q_d[i]      <= h3_d;
          q_h[i]      <= h3_h;
        end
      end
    end else begin : g_next
      dcb_div_cell #(.NW(QNW), .DW(PAR_W)) u_cell (
        .clk(clk), .en(en),
        .rem_i(q_rem[i-1]), .nq_i(q_nq[i-1]), .div_i(q_div[i-1]),
        .rem_o(q_rem[i]), .nq_o(q_nq[i]), .div_o(q_div[i])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          q_region[i] <= q_region[i-1];
          q_d[i]      <= q_d[i-1];
          q_h[i]      <= q_h[i-1];
        end
      end
    end
  end

  // s = q + d, log arguments
  logic [LW-1:0] s_sum, s_xq, s_xs;
  region_t       s_region;
  logic [HW-1:0] s_h;

  assign s_sum = LW'(q_nq[QNW-1]) + (LW'(q_d[QNW-1]) << D_SH);

  always_ff @(posedge clk) begin
    if (en) begin
      s_region <= q_region[QNW-1];
      s_h      <= q_h[QNW-1];
      s_xq     <= (q_nq[QNW-1] == '0) ? LW'(1) : LW'(q_nq[QNW-1]);
      s_xs     <= (s_sum == '0) ? LW'(1) : s_sum;
    end
  end

  // normalize
  logic [LW-1:0] nm_xq [KW];
  logic [LW-1:0] nm_xs [KW];
  logic [KW-1:0] nm_kq [KW];
  logic [KW-1:0] nm_ks [KW];
  region_t       nm_region [KW];
  logic [HW-1:0] nm_h [KW];

  for (genvar j = 0; j < KW; j++) begin : g_nm
    localparam int SH = 1 << (KW - 1 - j);
    logic [LW-1:0] xq_i, xs_i;
    logic [KW-1:0] kq_i, ks_i;
    region_t       rg_i;
    logic [HW-1:0] h_i;
    if (j == 0) begin : g_first
      assign xq_i = s_xq;
      assign xs_i = s_xs;
      assign kq_i = KW'(LW - 1);
      assign ks_i = KW'(LW - 1);
      assign rg_i = s_region;
      assign h_i  = s_h;
    end else begin : g_next
      assign xq_i = nm_xq[j-1];
      assign xs_i = nm_xs[j-1];
      assign kq_i = nm_kq[j-1];
      assign ks_i = nm_ks[j-1];
      assign rg_i = nm_region[j-1];
      assign h_i  = nm_h[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (xq_i[LW-1 -: SH] == '0) begin
          nm_xq[j] <= xq_i << SH;
          nm_kq[j] <= kq_i - KW'(SH);
        end else begin
          nm_xq[j] <= xq_i;
          nm_kq[j] <= kq_i;
        end
        if (xs_i[LW-1 -: SH] == '0) begin
          nm_xs[j] <= xs_i << SH;
          nm_ks[j] <= ks_i - KW'(SH);
        end else begin
          nm_xs[j] <= xs_i;
          nm_ks[j] <= ks_i;
        end
        nm_region[j] <= rg_i;
        nm_h[j]      <= h_i;
      end
    end
  end

  // log2 fraction by repeated squaring
  logic [YW-1:0]       lq_y [LOG_FRAC];
  logic [YW-1:0]       ls_y [LOG_FRAC];
  logic [LOG_FRAC-1:0] lq_f [LOG_FRAC];
  logic [LOG_FRAC-1:0] ls_f [LOG_FRAC];
  logic [KW-1:0]       lg_kq [LOG_FRAC];
  logic [KW-1:0]       lg_ks [LOG_FRAC];
  region_t             lg_region [LOG_FRAC];
  logic [HW-1:0]       lg_h [LOG_FRAC];

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_lg
    if (i == 0) begin : g_first
      dcb_lg_cell u_q (
        .clk(clk), .en(en),
        .y_i(nm_xq[KW-1][LW-1 -: YW]), .frac_i('0),
        .y_o(lq_y[i]), .frac_o(lq_f[i])
      );
      dcb_lg_cell u_s (
        .clk(clk), .en(en),
        .y_i(nm_xs[KW-1][LW-1 -: YW]), .frac_i('0),
        .y_o(ls_y[i]), .frac_o(ls_f[i])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          lg_kq[i]     <= nm_kq[KW-1];
          lg_ks[i]     <= nm_ks[KW-1];
          lg_region[i] <= nm_region[KW-1];
          lg_h[i]      <= nm_h[KW-1];
        end
      end
    end else begin : g_next
      dcb_lg_cell u_q (
        .clk(clk), .en(en),
        .y_i(lq_y[i-1]), .frac_i(lq_f[i-1]),
        .y_o(lq_y[i]), .frac_o(lq_f[i])
      );
      dcb_lg_cell u_s (
        .clk(clk), .en(en),
        .y_i(ls_y[i-1]), .frac_i(ls_f[i-1]),
        .y_o(ls_y[i]), .frac_o(ls_f[i])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          lg_kq[i]     <= lg_kq[i-1];
          lg_ks[i]     <= lg_ks[i-1];
          lg_region[i] <= lg_region[i-1];
          lg_h[i]      <= lg_h[i-1];
        end
      end
    end
  end

  // exponent e = h + n * (lg s - lg q)
  logic [LG_W-1:0] lq_v, ls_v;
  logic [POW_W-1:0] e1_n_sel, e2_n_sel;
  region_t         e1_region, e2_region, e3_region, e4_region;
  logic [HW-1:0]   e1_h, e2_h;
  logic [LG_W-1:0] e1_l;
  logic [POW_W+LH-1:0] e2_ph;
  logic [POW_W+LH-1:0] e2_pl;
  logic [EW-1:0]   e3_e;
  logic [EW-1:0]   e3_prod;
  logic            e4_zero;
  logic [KW:0]     e4_ip;
  logic [LOG_FRAC-1:0] e4_f;
  logic [LOG_FRAC-1:0] e3_fr;

  assign lq_v     = {lg_kq[LOG_FRAC-1], lq_f[LOG_FRAC-1]};
  assign ls_v     = {lg_ks[LOG_FRAC-1], ls_f[LOG_FRAC-1]};
  assign e1_n_sel = (lg_region[LOG_FRAC-1] == REG_LEFT) ? left_power : right_power;
  assign e2_n_sel = (e1_region == REG_LEFT) ? left_power : right_power;

  always_ff @(posedge clk) begin
    if (en) begin
      e1_region <= lg_region[LOG_FRAC-1];
      e1_h      <= lg_h[LOG_FRAC-1];
      e1_l      <= (lg_region[LOG_FRAC-1] != REG_CORE && e1_n_sel != '0 && ls_v > lq_v)
                   ? (ls_v - lq_v) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_region <= e1_region;
      e2_h      <= e1_h;
      e2_ph     <= (POW_W+LH)'(e2_n_sel) * (POW_W+LH)'(e1_l[LG_W-1:LH]);
      e2_pl     <= (POW_W+LH)'(e2_n_sel) * (POW_W+LH)'(e1_l[LH-1:0]);
    end
  end

  assign e3_prod = (EW'(e2_ph) << LH) + EW'(e2_pl);

  always_ff @(posedge clk) begin
    if (en) begin
      e3_region <= e2_region;
      e3_e      <= EW'(e2_h) + (e3_prod >> FRAC_BITS);
    end
  end

  assign e3_fr = e3_e[LOG_FRAC-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      e4_region <= e3_region;
      e4_zero   <= e3_e >= (EW'(64) << LOG_FRAC);
      e4_ip     <= (KW+1)'(e3_e[LOG_FRAC+KW-1:LOG_FRAC]) + (KW+1)'(e3_fr != '0);
      e4_f      <= LOG_FRAC'(0) - e3_fr;
    end
  end

  // 2^f by nested square roots
  logic [SQ_W-1:0]     sq_v [NSQ];
  logic [SQ_W-1:0]     sq_r [NSQ];
  region_t             sq_region [NSQ];
  logic                sq_zero [NSQ];
  logic [KW:0]         sq_ip [NSQ];
  logic [LOG_FRAC-1:0] sq_f [NSQ];

  for (genvar r = 0; r < LOG_FRAC; r++) begin : g_root
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
      localparam int G = r * SQ_STEPS + j;
      logic [SQ_W-1:0] v_in, r_in;
      if (G == 0) begin : g_first
        logic [YW:0] ydbl;
        assign ydbl = e4_f[0] ? ((YW+1)'(1) << YW) : ((YW+1)'(1) << (YW - 1));
        assign v_in = SQ_W'(ydbl) << (YW - 1);
        assign r_in = '0;
        always_ff @(posedge clk) begin
          if (en) begin
            sq_region[G] <= e4_region;
            sq_zero[G]   <= e4_zero;
            sq_ip[G]     <= e4_ip;
            sq_f[G]      <= e4_f;
          end
        end
      end else begin : g_next
        if (j == 0) begin : g_head
          logic [YW:0] ydbl;
          assign ydbl = sq_f[G-1][r] ? {sq_r[G-1][YW-1:0], 1'b0}
                                     : {1'b0, sq_r[G-1][YW-1:0]};
          assign v_in = SQ_W'(ydbl) << (YW - 1);
          assign r_in = '0;
        end else begin : g_body
          assign v_in = sq_v[G-1];
          assign r_in = sq_r[G-1];
        end
        always_ff @(posedge clk) begin
          if (en) begin
            sq_region[G] <= sq_region[G-1];
            sq_zero[G]   <= sq_zero[G-1];
            sq_ip[G]     <= sq_ip[G-1];
            sq_f[G]      <= sq_f[G-1];
          end
        end
      end
      dcb_sqrt_cell #(.STEP(j)) u_cell (
        .clk(clk), .en(en),
        .v_i(v_in), .r_i(r_in),
        .v_o(sq_v[G]), .r_o(sq_r[G])
      );
    end
  end

  // N * 2^-e, round and saturate
  logic [YW-9:0]   yq;
  logic [PROD_SPLIT+YW-9:0] f1_ph, f1_pl;
  region_t         f1_region, f2_region;
  logic            f1_zero, f2_kill;
  logic [KW:0]     f1_ip;
  logic [SQ_W-1:0] f2_p;
  logic [KW:0]     f2_sh;
  logic [KW:0]     f2_sh_next;
  logic [KW:0]     f3_shr;
  logic [SQ_W-1:0] f3_sp, f3_r;

  assign yq = sq_r[NSQ-1][YW-1:8];

  always_ff @(posedge clk) begin
    if (en) begin
      f1_region <= sq_region[NSQ-1];
      f1_zero   <= sq_zero[NSQ-1];
      f1_ip     <= sq_ip[NSQ-1];
      f1_ph     <= (PROD_SPLIT+YW-8)'(amplitude[AMP_W-1:PROD_SPLIT]) * (PROD_SPLIT+YW-8)'(yq);
      f1_pl     <= (PROD_SPLIT+YW-8)'(amplitude[PROD_SPLIT-1:0]) * (PROD_SPLIT+YW-8)'(yq);
    end
  end

  assign f2_sh_next = (KW+1)'(RND_SH) + f1_ip;

  always_ff @(posedge clk) begin
    if (en) begin
      f2_region <= f1_region;
      f2_p      <= (SQ_W'(f1_ph) << PROD_SPLIT) + SQ_W'(f1_pl);
      f2_sh     <= f2_sh_next;
      f2_kill   <= f1_zero || (f2_sh_next >= (KW+1)'(SQ_W));
    end
  end

  assign f3_shr = f2_sh - (KW+1)'(1);
  assign f3_sp  = f2_p >> f3_shr[KW-1:0];
  assign f3_r   = {1'b0, f3_sp[SQ_W-1:1]} + SQ_W'(f3_sp[0]);

  always_ff @(posedge clk) begin
    if (en) begin
      o_region <= f2_region;
      if (f2_kill) begin
        o_value <= '0;
      end else if (f3_r > SQ_W'(OUT_MAX)) begin
        o_value <= OUT_MAX;
      end else begin
        o_value <= f3_r[AMP_W-1:0];
      end
    end
  end

endmodule
